### hdl/gmc_pkg.sv
// Shared constants, types and command/status structs for the graph coloring search.
`timescale 1ns / 1ps
package gmc_pkg;

	localparam int MAX_VERTICES = 8;
	localparam int COLOR_BITS   = 3;
	localparam int VIDX_W       = $clog2(MAX_VERTICES);
	localparam int MAX_COLORS   = 1 << COLOR_BITS;
	// Count width: must hold MAX_VERTICES and MAX_COLORS themselves.
	localparam int CNT_W        = ($clog2(MAX_VERTICES + 1) > COLOR_BITS + 1) ?
	                              $clog2(MAX_VERTICES + 1) : COLOR_BITS + 1;
	localparam int PACK_W       = MAX_VERTICES * COLOR_BITS;
	localparam int CFG_W        = 4;
	localparam int CFG_IDX_W    = 2;

	localparam logic [CFG_IDX_W-1:0] REG_NUM_VERTICES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_COLORS   = 2'd1;

	localparam logic OP_LOAD_ROW = 1'b0;
	localparam logic OP_NEXT     = 1'b1;

	localparam logic [CFG_W-1:0] NUM_VERTICES_RST = 4'd8;
	localparam logic [CFG_W-1:0] NUM_COLORS_RST   = 4'd3;

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_BACK  = 3'b010,
		S_CHECK = 3'b100
	} state_t;

	typedef enum logic [1:0] {
		PH_FRESH   = 2'd0,
		PH_RUNNING = 2'd1,
		PH_DONE    = 2'd2
	} phase_t;

	typedef struct packed {
		logic req;    // advance to the next coloring
		logic clear;  // put the search back to fresh
	} search_cmd_t;

	typedef struct packed {
		logic              done;
		logic              found;
		logic              exhausted;
		logic [PACK_W-1:0] colors;
	} search_rsp_t;

endpackage

### hdl/gmc_search.sv
// Backtracking search engine: sequencer, color store and one shared neighbor comparator.
`timescale 1ns / 1ps
module gmc_search (
	input  logic                          clk,
	input  logic                          arst_n,
	input  gmc_pkg::search_cmd_t          cmd,
	input  logic [gmc_pkg::CNT_W-1:0]     n_eff,
	input  logic [gmc_pkg::CNT_W-1:0]     m_eff,
	input  logic [gmc_pkg::MAX_VERTICES-1:0] adj_row,
	output logic [gmc_pkg::VIDX_W-1:0]    depth,
	output logic                          busy,
	output gmc_pkg::search_rsp_t          rsp
);

	gmc_pkg::state_t state_q;
	gmc_pkg::phase_t phase_q;
	logic [gmc_pkg::VIDX_W-1:0]     d_q;
	logic [gmc_pkg::VIDX_W-1:0]     i_q;
	logic [gmc_pkg::CNT_W-1:0]      c_q;
	logic [gmc_pkg::COLOR_BITS-1:0] colors_q [gmc_pkg::MAX_VERTICES];
	logic                           done_q;
	logic                           found_q;
	logic [gmc_pkg::PACK_W-1:0]     packed_q;

	logic [gmc_pkg::VIDX_W-1:0]     rd_idx;
	logic [gmc_pkg::COLOR_BITS-1:0] rd_color;
	logic                           conflict;
	logic                           last_vertex;
	logic [gmc_pkg::PACK_W-1:0]     packed_next;

	// Single read port: backtrack reads the vertex being revisited, check reads the neighbor.
	assign rd_idx   = (state_q == gmc_pkg::S_BACK) ? d_q : i_q;
	assign rd_color = colors_q[rd_idx];
	assign conflict = adj_row[i_q] && (rd_color == c_q[gmc_pkg::COLOR_BITS-1:0]);
	assign last_vertex = ({{(gmc_pkg::CNT_W-gmc_pkg::VIDX_W){1'b0}}, d_q} + 1'b1) == n_eff;

	always_comb begin
		logic [gmc_pkg::COLOR_BITS-1:0] entry;
		packed_next = '0;
		for (int v = 0; v < gmc_pkg::MAX_VERTICES; v++) begin
			entry = (gmc_pkg::VIDX_W'(v) == d_q) ? c_q[gmc_pkg::COLOR_BITS-1:0] : colors_q[v];
			if (gmc_pkg::CNT_W'(v) < n_eff) begin
				packed_next[v*gmc_pkg::COLOR_BITS +: gmc_pkg::COLOR_BITS] = entry;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gmc_pkg::S_IDLE;
			phase_q <= gmc_pkg::PH_FRESH;
			d_q     <= '0;
			i_q     <= '0;
			c_q     <= '0;
			done_q  <= 1'b0;
			found_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				gmc_pkg::S_IDLE: begin
					if (cmd.clear) begin
						phase_q <= gmc_pkg::PH_FRESH;
					end else if (cmd.req) begin
						unique case (phase_q)
							gmc_pkg::PH_FRESH: begin
								d_q     <= '0;
								i_q     <= '0;
								c_q     <= '0;
								state_q <= gmc_pkg::S_CHECK;
							end
							gmc_pkg::PH_RUNNING: begin
								d_q     <= gmc_pkg::VIDX_W'(n_eff - 1'b1);
								state_q <= gmc_pkg::S_BACK;
							end
							default: begin
								done_q  <= 1'b1;
								found_q <= 1'b0;
							end
						endcase
					end
				end
				gmc_pkg::S_BACK: begin
					c_q     <= {{(gmc_pkg::CNT_W-gmc_pkg::COLOR_BITS){1'b0}}, rd_color} + 1'b1;
					i_q     <= '0;
					state_q <= gmc_pkg::S_CHECK;
				end
				gmc_pkg::S_CHECK: begin
					priority if (c_q >= m_eff) begin
						if (d_q == '0) begin
							phase_q <= gmc_pkg::PH_DONE;
							done_q  <= 1'b1;
							found_q <= 1'b0;
							state_q <= gmc_pkg::S_IDLE;
						end else begin
							d_q     <= d_q - 1'b1;
							state_q <= gmc_pkg::S_BACK;
						end
					end else if (i_q == d_q) begin
						if (last_vertex) begin
							phase_q <= gmc_pkg::PH_RUNNING;
							done_q  <= 1'b1;
							found_q <= 1'b1;
							state_q <= gmc_pkg::S_IDLE;
						end else begin
							d_q <= d_q + 1'b1;
							c_q <= '0;
							i_q <= '0;
						end
					end else if (conflict) begin
						c_q <= c_q + 1'b1;
						i_q <= '0;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				default: state_q <= gmc_pkg::S_IDLE;
			endcase
		end
	end

	// Color store and result payload: no reset.
	always_ff @(posedge clk) begin
		if (state_q == gmc_pkg::S_CHECK && c_q < m_eff && i_q == d_q) begin
			colors_q[d_q] <= c_q[gmc_pkg::COLOR_BITS-1:0];
		end
		if (state_q == gmc_pkg::S_CHECK && c_q < m_eff && i_q == d_q && last_vertex) begin
			packed_q <= packed_next;
		end else begin
			packed_q <= '0;
		end
	end

	assign depth         = d_q;
	assign busy          = (state_q != gmc_pkg::S_IDLE);
	assign rsp.done      = done_q;
	assign rsp.found     = done_q && found_q;
	assign rsp.exhausted = done_q && !found_q;
	assign rsp.colors    = done_q ? packed_q : '0;

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q)) else $error("search state not one-hot");
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == gmc_pkg::S_CHECK |-> i_q <= d_q) else $error("neighbor scan past depth");
	a_exhaust_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && !found_q) |-> phase_q == gmc_pkg::PH_DONE)
		else $error("exhausted answer without done phase");
	a_found_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && found_q) |-> phase_q == gmc_pkg::PH_RUNNING)
		else $error("coloring reported outside running phase");
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == gmc_pkg::S_CHECK) || $past(cmd.req))
		else $error("result strobe without request");

endmodule

### hdl/graph_m_coloring_search_top.sv
// Top level of the graph m-coloring backtracking search: ports, registers, adjacency rows.
`timescale 1ns / 1ps
// Graph m-coloring search. Load commands (opcode 0) store one adjacency row and
// put the search back to its fresh state; they give no result.
// Next commands (opcode 1) return the next proper coloring in depth-first order
// (vertex 0 most significant, colors ascending), or search_exhausted once none is
// left. A command is taken when start is high and busy is low. Each result shows
// on colors_packed / coloring_valid / search_exhausted for exactly one cycle with
// done high; the receiver cannot stall it, so sample it on that cycle.
// Course of a next command: the sequencer runs one neighbor compare per cycle
// while it checks, and a rejected color try ends early at its first conflict;
// running out of colors at a vertex steps back to the previous vertex, which
// rereads its color. A request that resumes after a coloring starts with one
// such step back. The strobe is registered from the check step that ends the
// search. The single shared neighbor comparator, stepped by the sequencer, sets
// the run time of a request, which grows long when the search dies late in many
// branches, as on dense graphs with many colors. A request after exhaustion
// strobes in the cycle right after it is taken. Register writes go through the
// cfg channel while busy is low (index 0 num_vertices, 1 num_colors); any write
// to a known register also restarts the search. Vertices at or above the
// clamped vertex count read as color 0.
module graph_m_coloring_search_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                opcode,
	input  logic [gmc_pkg::VIDX_W-1:0]          row_index,
	input  logic [gmc_pkg::MAX_VERTICES-1:0]    row_bits,
	output logic                                done,
	output logic [gmc_pkg::PACK_W-1:0]          colors_packed,
	output logic                                coloring_valid,
	output logic                                search_exhausted,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [gmc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [gmc_pkg::CFG_W-1:0]           cfg_data
);

	logic [gmc_pkg::CFG_W-1:0]        num_vertices_q;
	logic [gmc_pkg::CFG_W-1:0]        num_colors_q;
	logic [gmc_pkg::MAX_VERTICES-1:0] adj_q [gmc_pkg::MAX_VERTICES];

	logic                       cmd_xfer;
	logic                       cfg_xfer;
	logic                       cfg_hit;
	logic [gmc_pkg::CNT_W-1:0]  n_eff;
	logic [gmc_pkg::CNT_W-1:0]  m_eff;
	logic [gmc_pkg::VIDX_W-1:0] depth;
	gmc_pkg::search_cmd_t       cmd;
	gmc_pkg::search_rsp_t       rsp;

	// A command transfer happens only while the engine is idle.
	assign cmd_xfer  = start && !busy;
	assign cfg_ready = !busy;
	assign cfg_xfer  = cfg_valid && cfg_ready;
	assign cfg_hit   = cfg_xfer && (cfg_index == gmc_pkg::REG_NUM_VERTICES ||
	                                cfg_index == gmc_pkg::REG_NUM_COLORS);

	// Clamp register values into the range the search supports.
	always_comb begin
		priority if (num_vertices_q == '0) begin
			n_eff = gmc_pkg::CNT_W'(1);
		end else if (gmc_pkg::CNT_W'(num_vertices_q) > gmc_pkg::CNT_W'(gmc_pkg::MAX_VERTICES)) begin
			n_eff = gmc_pkg::CNT_W'(gmc_pkg::MAX_VERTICES);
		end else begin
			n_eff = gmc_pkg::CNT_W'(num_vertices_q);
		end
		if (gmc_pkg::CNT_W'(num_colors_q) > gmc_pkg::CNT_W'(gmc_pkg::MAX_COLORS)) begin
			m_eff = gmc_pkg::CNT_W'(gmc_pkg::MAX_COLORS);
		end else begin
			m_eff = gmc_pkg::CNT_W'(num_colors_q);
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_vertices_q <= gmc_pkg::NUM_VERTICES_RST;
			num_colors_q   <= gmc_pkg::NUM_COLORS_RST;
		end else if (cfg_xfer) begin
			if (cfg_index == gmc_pkg::REG_NUM_VERTICES) begin
				num_vertices_q <= cfg_data;
			end
			if (cfg_index == gmc_pkg::REG_NUM_COLORS) begin
				num_colors_q <= cfg_data;
			end
		end
	end

	// Adjacency rows: reset to no edges; a load overwrites one row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < gmc_pkg::MAX_VERTICES; r++) begin
				adj_q[r] <= '0;
			end
		end else if (cmd_xfer && opcode == gmc_pkg::OP_LOAD_ROW) begin
			adj_q[row_index] <= row_bits;
		end
	end

	// Load and known register writes both restart the search.
	assign cmd.req   = cmd_xfer && opcode == gmc_pkg::OP_NEXT;
	assign cmd.clear = (cmd_xfer && opcode == gmc_pkg::OP_LOAD_ROW) || cfg_hit;

	gmc_search u_search (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.n_eff   (n_eff),
		.m_eff   (m_eff),
		.adj_row (adj_q[depth]),
		.depth   (depth),
		.busy    (busy),
		.rsp     (rsp)
	);

	// Result strobe and payload come straight from the engine's output registers.
	assign done             = rsp.done;
	assign colors_packed    = rsp.colors;
	assign coloring_valid   = rsp.found;
	assign search_exhausted = rsp.exhausted;

endmodule

### tb/graph_m_coloring_search_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the graph m-coloring backtracking search top level.
module graph_m_coloring_search_top_tb;
	import gmc_pkg::*;

	localparam int N_ITEMS       = 1350;
	localparam int N_RESET       = 10;
	// Loads give no result; leave spare cycles before touching the register channel.
	localparam int SETTLE_CYCLES = 8;

	// The two register indexes that the block does not decode.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

	typedef struct packed {
		logic [PACK_W-1:0] colors;
		logic              valid;
		logic              exhausted;
	} coloring_t;

	localparam coloring_t ANS_DONE = '{colors: '0, valid: 1'b0, exhausted: 1'b1};

	typedef enum logic {STEP_CFG, STEP_ITEM} step_kind_t;

	// One row of the directed table: either a register write or a command,
	// with an optional hand-typed answer for requests.
	typedef struct packed {
		step_kind_t              kind;
		logic                    op;
		logic [VIDX_W-1:0]       row;
		logic [MAX_VERTICES-1:0] bits;
		logic [CFG_IDX_W-1:0]    reg_idx;
		logic [CFG_W-1:0]        reg_val;
		logic                    fixed;
		coloring_t               answer;
	} script_step_t;

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic                    opcode;
	logic [VIDX_W-1:0]       row_index;
	logic [MAX_VERTICES-1:0] row_bits;
	logic                    done;
	logic [PACK_W-1:0]       colors_packed;
	logic                    coloring_valid;
	logic                    search_exhausted;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_W-1:0]        cfg_data;

	// Predictor state: our own copy of the graph, the partial coloring,
	// the search phase and both registers.
	logic [MAX_VERTICES-1:0] adj_rows [MAX_VERTICES];
	logic [COLOR_BITS-1:0]   held_colors [MAX_VERTICES];
	phase_t                  walk_phase;
	logic [CFG_W-1:0]        vertex_cfg;
	logic [CFG_W-1:0]        color_cfg;

	// Answers still owed by the block, oldest first.
	coloring_t pending_colorings [$];

	// Hand-typed answer for the command currently on the ports, if any.
	bit        fixed_on;
	coloring_t fixed_answer;

	bit           burst_gapless;
	int           items_sent;
	int           mismatch_count;
	script_step_t directed_script [$];

	graph_m_coloring_search_top i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.opcode           (opcode),
		.row_index        (row_index),
		.row_bits         (row_bits),
		.done             (done),
		.colors_packed    (colors_packed),
		.coloring_valid   (coloring_valid),
		.search_exhausted (search_exhausted),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	always #2 clk = ~clk;

	// ---------------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------------

	// Clamp the vertex register: zero acts as one, anything past the array
	// size acts as the array size.
	function automatic int vertices_in_use();
		if (vertex_cfg == 0) return 1;
		if (vertex_cfg > MAX_VERTICES) return MAX_VERTICES;
		return int'(vertex_cfg);
	endfunction

	// Clamp the color register to what the color field can hold; zero stays zero.
	function automatic int colors_in_use();
		return (color_cfg > MAX_COLORS) ? MAX_COLORS : int'(color_cfg);
	endfunction

	// Only the row of the vertex being colored counts, and only toward
	// vertices already colored, so self loops and one-way edges are harmless.
	function automatic bit color_free(int d, int c);
		for (int i = 0; i < d; i++)
			if (adj_rows[d][i] && held_colors[i] == c) return 1'b0;
		return 1'b1;
	endfunction

	// Advance the depth-first walk to the next full coloring and build the answer.
	function automatic coloring_t next_coloring();
		int        n;
		int        m;
		int        d;
		int        c;
		coloring_t ans;
		n   = vertices_in_use();
		m   = colors_in_use();
		ans = ANS_DONE;
		if (walk_phase == PH_DONE) return ans;
		if (walk_phase == PH_FRESH) begin
			d = 0;
			c = 0;
		end else begin
			// Resume from the last vertex with its next color.
			d = n - 1;
			c = int'(held_colors[d]) + 1;
		end
		while (1'b1) begin
			if (c < m) begin
				if (color_free(d, c)) begin
					held_colors[d] = c[COLOR_BITS-1:0];
					d++;
					if (d == n) begin
						walk_phase    = PH_RUNNING;
						ans.valid     = 1'b1;
						ans.exhausted = 1'b0;
						// Vertices above the count stay packed as zero.
						for (int i = 0; i < n; i++)
							ans.colors[i*COLOR_BITS +: COLOR_BITS] = held_colors[i];
						return ans;
					end
					c = 0;
				end else begin
					c++;
				end
			end else begin
				if (d == 0) begin
					walk_phase = PH_DONE;
					return ans;
				end
				// Back up one vertex and try its next color.
				d--;
				c = int'(held_colors[d]) + 1;
			end
		end
		return ans;
	endfunction

	// ---------------------------------------------------------------------
	// Checking
	// ---------------------------------------------------------------------

	task automatic report_mismatch(string what, logic [PACK_W-1:0] got,
	                               logic [PACK_W-1:0] want);
		$display("%0t: %s: got %h, want %h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// Sample everything at the rising edge. Check the result first, then
	// advance the predictor on a command transfer, then on a register transfer.
	always @(posedge clk) begin : scoreboard
		coloring_t want;
		if (arst_n) begin
			if (done) begin
				if (pending_colorings.size() == 0) begin
					report_mismatch("result with nothing pending", colors_packed, '0);
				end else begin
					want = pending_colorings.pop_front();
					if (colors_packed !== want.colors)
						report_mismatch("colors_packed", colors_packed, want.colors);
					if (coloring_valid !== want.valid)
						report_mismatch("coloring_valid", coloring_valid, want.valid);
					if (search_exhausted !== want.exhausted)
						report_mismatch("search_exhausted", search_exhausted,
						                want.exhausted);
				end
			end
			if (start && !busy) begin
				if (opcode == OP_LOAD_ROW) begin
					// Store the row and send the walk back to its fresh state.
					adj_rows[row_index] = row_bits;
					walk_phase          = PH_FRESH;
				end else begin
					want = next_coloring();
					// A typed answer takes the place of the predicted one; the
					// predictor state still moves on.
					if (fixed_on) want = fixed_answer;
					pending_colorings.push_back(want);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_NUM_VERTICES: begin
						vertex_cfg = cfg_data;
						walk_phase = PH_FRESH;
					end
					REG_NUM_COLORS: begin
						color_cfg  = cfg_data;
						walk_phase = PH_FRESH;
					end
					// Unknown indexes leave the search alone.
					default: ;
				endcase
			end
		end
	end

	// ---------------------------------------------------------------------
	// Driving: everything changes at the falling edge
	// ---------------------------------------------------------------------

	// Mostly back-to-back or short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (burst_gapless || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [MAX_VERTICES-1:0] random_row();
		case ($urandom_range(0, 3))
			0:       return '0;
			1:       return '1;
			2:       return MAX_VERTICES'($urandom);
			default: return MAX_VERTICES'($urandom & $urandom);
		endcase
	endfunction

	// Present one command and hold it until the transfer; return at the
	// falling edge after it with start still high, so a following command
	// can go out with no bubble.
	task automatic send_item(logic op, logic [VIDX_W-1:0] row,
	                         logic [MAX_VERTICES-1:0] bits, bit typed, coloring_t answer);
		int gap;
		gap = pick_gap();
		cfg_valid <= 1'b0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		fixed_on     = typed;
		fixed_answer = answer;
		start     <= 1'b1;
		opcode    <= op;
		row_index <= row;
		row_bits  <= bits;
		do @(posedge clk); while (busy);
		@(negedge clk);
		items_sent++;
	endtask

	// Drop start and wait until every owed answer is in and the block is idle.
	task automatic wait_drained();
		start     <= 1'b0;
		cfg_valid <= 1'b0;
		while (pending_colorings.size() != 0 || busy) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// One register transfer; valid is left high so writes can go back to back.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	// Directed table row builders.
	function automatic script_step_t cfg_step(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		script_step_t s;
		s         = '0;
		s.kind    = STEP_CFG;
		s.reg_idx = idx;
		s.reg_val = val;
		return s;
	endfunction

	function automatic script_step_t load_step(logic [VIDX_W-1:0] row,
	                                           logic [MAX_VERTICES-1:0] bits);
		script_step_t s;
		s      = '0;
		s.kind = STEP_ITEM;
		s.op   = OP_LOAD_ROW;
		s.row  = row;
		s.bits = bits;
		return s;
	endfunction

	function automatic script_step_t next_step(bit typed, coloring_t answer);
		script_step_t s;
		s        = '0;
		s.kind   = STEP_ITEM;
		s.op     = OP_NEXT;
		s.fixed  = typed;
		s.answer = answer;
		return s;
	endfunction

	// Run-time limit, far beyond any correct run.
	initial begin
		#200ms;
		$display("tb: failure");
		$finish;
	end

	initial begin : stimulus
		int v;
		int v_used;
		int c;
		clk            = 1'b0;
		arst_n         = 1'b0;
		start          = 1'b0;
		opcode         = OP_LOAD_ROW;
		row_index      = '0;
		row_bits       = '0;
		cfg_valid      = 1'b0;
		cfg_index      = REG_NUM_VERTICES;
		cfg_data       = '0;
		fixed_on       = 1'b0;
		fixed_answer   = '0;
		burst_gapless  = 1'b0;
		items_sent     = 0;
		mismatch_count = 0;
		for (int i = 0; i < MAX_VERTICES; i++) begin
			adj_rows[i]    = '0;
			held_colors[i] = '0;
		end
		walk_phase = PH_FRESH;
		vertex_cfg = NUM_VERTICES_RST;
		color_cfg  = NUM_COLORS_RST;

		// Directed table. Typed answers are the ones that are plain by hand (the
		// reset graph with no edges, 8 vertices, 3 colors, and one vertex with one
		// color) or that are exhausted; the rest go through the predictor.
		directed_script = {
			// Reset graph: first coloring all zero, then the last vertex counts up.
			next_step(1'b1, '{colors: 24'h000000, valid: 1'b1, exhausted: 1'b0}),
			next_step(1'b1, '{colors: 24'h200000, valid: 1'b1, exhausted: 1'b0}),
			next_step(1'b1, '{colors: 24'h400000, valid: 1'b1, exhausted: 1'b0}),
			next_step(1'b0, '0),
			// Smallest sizes: a single coloring, then exhausted and it stays so.
			cfg_step(REG_NUM_VERTICES, 4'd1),
			cfg_step(REG_NUM_COLORS, 4'd1),
			next_step(1'b1, '{colors: 24'h000000, valid: 1'b1, exhausted: 1'b0}),
			next_step(1'b1, ANS_DONE),
			next_step(1'b1, ANS_DONE),
			// No colors at all: exhausted at once.
			cfg_step(REG_NUM_COLORS, 4'd0),
			next_step(1'b1, ANS_DONE),
			// Out-of-range counts get clamped.
			cfg_step(REG_NUM_VERTICES, 4'd0),
			cfg_step(REG_NUM_COLORS, 4'd15),
			next_step(1'b0, '0),
			next_step(1'b0, '0),
			// All vertices, two colors, self loops and one-way edges.
			cfg_step(REG_NUM_VERTICES, 4'd15),
			cfg_step(REG_NUM_COLORS, 4'd2),
			load_step(3'd7, 8'hFF),
			load_step(3'd0, 8'hFF),
			load_step(3'd3, 8'h81),
			next_step(1'b0, '0),
			next_step(1'b0, '0),
			// Triangle on vertices 0..2 with three colors.
			cfg_step(REG_NUM_VERTICES, 4'd3),
			cfg_step(REG_NUM_COLORS, 4'd3),
			load_step(3'd1, 8'h01),
			load_step(3'd2, 8'h03),
			next_step(1'b0, '0),
			next_step(1'b0, '0),
			// Writes to undecoded indexes must not restart the walk.
			cfg_step(REG_UNUSED_3, 4'd9),
			cfg_step(REG_UNUSED_2, 4'd15),
			next_step(1'b0, '0),
			// A load of an unused row still restarts the walk.
			load_step(3'd5, 8'hAA),
			next_step(1'b0, '0),
			// Triangle with two colors has no coloring.
			cfg_step(REG_NUM_COLORS, 4'd2),
			next_step(1'b1, ANS_DONE)
		};

		repeat (N_RESET) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Walk the table. Register rows wait for the block to go idle first.
		foreach (directed_script[k]) begin
			if (directed_script[k].kind == STEP_CFG) begin
				wait_drained();
				write_reg(directed_script[k].reg_idx, directed_script[k].reg_val);
			end else begin
				send_item(directed_script[k].op, directed_script[k].row,
				          directed_script[k].bits, directed_script[k].fixed,
				          directed_script[k].answer);
			end
		end

		// Random phases: idle, set both registers, load a few rows, then a
		// burst of requests with some stray loads and full pauses mixed in.
		// Wide graphs get few colors so a single request stays short.
		while (items_sent < N_ITEMS) begin
			wait_drained();
			burst_gapless = ($urandom_range(0, 3) == 0);
			c = $urandom_range(0, 99);
			if (c < 70)      v = $urandom_range(1, 5);
			else if (c < 90) v = $urandom_range(6, 8);
			else             v = $urandom_range(0, 15);
			v_used = (v == 0) ? 1 : ((v > MAX_VERTICES) ? MAX_VERTICES : v);
			if (v_used >= 6)                     c = $urandom_range(0, 4);
			else if ($urandom_range(0, 99) < 80) c = $urandom_range(1, 5);
			else                                 c = $urandom_range(0, 15);
			write_reg(REG_NUM_VERTICES, CFG_W'(v));
			write_reg(REG_NUM_COLORS, CFG_W'(c));
			if ($urandom_range(0, 19) == 0)
				write_reg($urandom_range(0, 1) ? REG_UNUSED_2 : REG_UNUSED_3,
				          CFG_W'($urandom_range(0, 15)));
			repeat ($urandom_range(0, 6))
				send_item(OP_LOAD_ROW, VIDX_W'($urandom_range(0, 7)), random_row(),
				          1'b0, '0);
			repeat ($urandom_range(1, 40)) begin
				c = $urandom_range(0, 99);
				if (c < 4) begin
					send_item(OP_LOAD_ROW, VIDX_W'($urandom_range(0, 7)), random_row(),
					          1'b0, '0);
				end else begin
					// Hold the sender until every owed answer is in.
					if (c < 7) wait_drained();
					send_item(OP_NEXT, VIDX_W'($urandom_range(0, 7)),
					          MAX_VERTICES'($urandom), 1'b0, '0);
				end
			end
		end

		wait_drained();
		if (mismatch_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
